[design/geometric_rans_symbol_encoder_assert.svh]
// Assertion macros for the geometric rANS symbol encoder.
// Included by the top level; depends on nothing else.
`ifndef GEOMETRIC_RANS_SYMBOL_ENCODER_ASSERT_SVH
`define GEOMETRIC_RANS_SYMBOL_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GRANS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grans assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define GRANS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grans assertion failed: next-cycle implication");

`endif

[design/grans_pkg.sv]
// Shared types and constants of the geometric rANS symbol encoder.
// Used by the channel interfaces, the divider, the packer and the top level.
package grans_pkg;

   localparam int unsigned VALUE_W = 8;
   localparam int unsigned PROB_W  = 16;
   localparam int unsigned STATE_W = 32;
   localparam int unsigned FREQ_W  = 16;
   localparam int unsigned QUOT_W  = 15;
   localparam int unsigned OUT_W   = 64;
   localparam int unsigned COUNT_W = 4;

   localparam logic [STATE_W-1:0] LOW_BOUND = 32'h0080_0000;
   localparam logic [PROB_W-1:0]  PROB_MIN  = 16'd655;
   localparam logic [PROB_W-1:0]  PROB_MAX  = 16'd64880;
   localparam logic [PROB_W-1:0]  HALF_PROB = 16'd32768;

   typedef enum logic {
      KIND_SYMBOL = 1'b0,
      KIND_FLUSH  = 1'b1
   } grans_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_RENORM,
      ST_DIVIDE,
      ST_FINISH
   } grans_state_type;

   typedef enum logic [1:0] {
      PH_STOP,
      PH_ZERO,
      PH_SIGN
   } grans_phase_type;

   // Command from the sequencer to the byte packer.
   typedef struct packed {
      logic       push;
      logic       finish;
      logic [7:0] data;
   } grans_pack_cmd_type;

endpackage

[design/grans_req_if.sv]
// Input channel of the geometric rANS symbol encoder: valid/ready plus symbol payload.
// Depends on grans_pkg for field widths.
interface grans_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [grans_pkg::VALUE_W-1:0] value;
   logic        [grans_pkg::PROB_W-1:0]  zero_prob;

   modport source (output valid, output kind, output value, output zero_prob, input ready);
   modport sink   (input valid, input kind, input value, input zero_prob, output ready);
endinterface

[design/grans_rsp_if.sv]
// Result channel of the geometric rANS symbol encoder: valid/ready plus byte group.
// Depends on grans_pkg for field widths.
interface grans_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [grans_pkg::OUT_W-1:0]      out_bytes;
   logic [grans_pkg::COUNT_W-1:0]    byte_count;
   logic                             last;

   modport source (output valid, output out_bytes, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input out_bytes, input byte_count, input last,
                   output ready);
endinterface

[design/geometric_rans_symbol_encoder.sv]
// Geometric rANS symbol encoder top level: sequencer, shared divider and byte packer.
// Each coded bit takes a divider start, 15 divider steps and a state update, plus a
// byte push per renormalization byte and any wait of a full group on the result side.
// A symbol of magnitude m codes m + 2 bits and a flush pushes four bytes; a new input
// is accepted only once the last item is through. The serial divider sets the rate.
// Synchronous reset: coder state returns to 2^23, no beat is pending, input is ready.
`include "geometric_rans_symbol_encoder_assert.svh"

module geometric_rans_symbol_encoder #(
   parameter int unsigned GROUP_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   grans_req_if.sink  req,
   grans_rsp_if.source rsp
);
   import grans_pkg::*;

   grans_state_type    state_ff, state_in;
   grans_phase_type    phase_ff, phase_in;
   logic [STATE_W-1:0] x_ff, x_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [PROB_W-1:0]  prob_ff, prob_in;
   logic [1:0]         fcnt_ff, fcnt_in;

   logic               accept;
   logic [PROB_W-1:0]  prob_clamped;
   logic               bit_val;
   logic [PROB_W-1:0]  bit_prob;
   logic [FREQ_W-1:0]  freq;
   logic [PROB_W-1:0]  start_val;
   logic [STATE_W-1:0] x_max;
   logic               need_byte;
   logic [7:0]         flush_byte;

   grans_pack_cmd_type cmd;
   logic               cmd_ok;
   logic               div_start;
   logic               div_done;
   logic [QUOT_W-1:0]  div_quot;
   logic [FREQ_W-1:0]  div_rem;

   assign req.ready = state_ff == ST_IDLE;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (req.zero_prob < PROB_MIN) begin
         prob_clamped = PROB_MIN;
      end else if (req.zero_prob > PROB_MAX) begin
         prob_clamped = PROB_MAX;
      end else begin
         prob_clamped = req.zero_prob;
      end
   end

   // Bit being coded in the current phase and its interval.
   always_comb begin
      unique case (phase_ff)
         PH_STOP: begin
            bit_val  = 1'b1;
            bit_prob = prob_ff;
         end
         PH_ZERO: begin
            bit_val  = 1'b0;
            bit_prob = prob_ff;
         end
         PH_SIGN: begin
            bit_val  = neg_ff;
            bit_prob = HALF_PROB;
         end
         default: begin
            bit_val  = 1'b0;
            bit_prob = prob_ff;
         end
      endcase
      freq      = bit_val ? FREQ_W'(17'h1_0000 - {1'b0, bit_prob}) : bit_prob;
      start_val = bit_val ? bit_prob : '0;
      x_max     = {1'b0, freq, 15'b0};
      need_byte = x_ff >= x_max;
   end

   always_comb begin
      case (fcnt_ff)
         2'd0:    flush_byte = x_ff[31:24];
         2'd1:    flush_byte = x_ff[23:16];
         2'd2:    flush_byte = x_ff[15:8];
         default: flush_byte = x_ff[7:0];
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req.kind == KIND_FLUSH) ? ST_FLUSH : ST_RENORM;
            end
         end
         ST_FLUSH: begin
            if (cmd_ok && fcnt_ff == 2'd3) begin
               state_in = ST_FINISH;
            end
         end
         ST_RENORM: begin
            if (!need_byte) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = (phase_ff == PH_SIGN) ? ST_FINISH : ST_RENORM;
            end
         end
         ST_FINISH: begin
            if (cmd_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and packer commands.
   always_comb begin
      phase_in   = phase_ff;
      x_in       = x_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      prob_in    = prob_ff;
      fcnt_in    = fcnt_ff;
      div_start  = 1'b0;
      cmd.push   = 1'b0;
      cmd.finish = 1'b0;
      cmd.data   = x_ff[7:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in = PH_STOP;
               neg_in   = req.value[VALUE_W-1];
               mag_in   = req.value[VALUE_W-1] ? 8'(-req.value) : req.value;
               prob_in  = prob_clamped;
               fcnt_in  = '0;
            end
         end
         ST_FLUSH: begin
            cmd.push = 1'b1;
            cmd.data = flush_byte;
            if (cmd_ok) begin
               fcnt_in = fcnt_ff + 1'b1;
               if (fcnt_ff == 2'd3) begin
                  x_in = LOW_BOUND;
               end
            end
         end
         ST_RENORM: begin
            if (need_byte) begin
               cmd.push = 1'b1;
               if (cmd_ok) begin
                  x_in = {8'd0, x_ff[STATE_W-1:8]};
               end
            end else begin
               div_start = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // Remainder plus start stays below 2^16, so no carry into the quotient.
               x_in = {1'b0, div_quot, div_rem + start_val};
               unique case (phase_ff)
                  PH_STOP: phase_in = (mag_ff == '0) ? PH_SIGN : PH_ZERO;
                  PH_ZERO: begin
                     mag_in = mag_ff - 1'b1;
                     if (mag_ff == VALUE_W'(1)) begin
                        phase_in = PH_SIGN;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd.finish = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_STOP;
         x_ff     <= LOW_BOUND;
         fcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         x_ff     <= x_in;
         fcnt_ff  <= fcnt_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prob_ff <= prob_in;
   end

   grans_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (x_ff[STATE_W-2:0]),
      .divisor   (freq),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   grans_packer #(
      .GROUP_BYTES (GROUP_BYTES)
   ) u_packer (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .cmd_ok (cmd_ok),
      .rsp    (rsp)
   );

   // Between items the coder state lies in [2^23, 2^31).
   `GRANS_ASSERT_IMP(a_state_range, clock, reset, state_ff == ST_IDLE, x_ff >= LOW_BOUND && !x_ff[STATE_W-1])
   `GRANS_ASSERT_IMP(a_div_done_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE)
   `GRANS_ASSERT_IMP(a_beat_count, clock, reset, rsp.valid, rsp.byte_count != '0 && rsp.byte_count <= COUNT_W'(GROUP_BYTES))
   `GRANS_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req.ready)

endmodule

[design/grans_divider.sv]
// Iterative restoring divider: one quotient bit per cycle.
// Depends on grans_pkg; the dividend must satisfy dividend < divisor * 2^15.
module grans_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [grans_pkg::STATE_W-2:0] dividend,
   input  logic [grans_pkg::FREQ_W-1:0]  divisor,
   output logic                          done,
   output logic [grans_pkg::QUOT_W-1:0]  quotient,
   output logic [grans_pkg::FREQ_W-1:0]  remainder
);
   import grans_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [FREQ_W:0]   trial;
   logic [FREQ_W:0]   diff;
   logic              fits;

   // The low word shifts out dividend bits at the top and collects quotient bits
   // at the bottom, so after the last step it holds the quotient.
   always_comb begin
      trial   = {rem_ff, low_ff[QUOT_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = trial >= {1'b0, divisor};
      rem_in  = rem_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend[STATE_W-2:QUOT_W];
         low_in = dividend[QUOT_W-1:0];
         cnt_in = CNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
         low_in  = {low_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign done      = done_ff;
   assign quotient  = low_ff;
   assign remainder = rem_ff;

endmodule

[design/grans_packer.sv]
// Byte packer: gathers emitted bytes into groups and holds them in the result register.
// Depends on grans_pkg and grans_rsp_if. A full group is held back until the next
// byte or the end of the item, so that the last flag can be set on the final beat.
module grans_packer #(
   parameter int unsigned GROUP_BYTES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  grans_pkg::grans_pack_cmd_type cmd,
   output logic                          cmd_ok,
   grans_rsp_if.source                   rsp
);
   import grans_pkg::*;

   logic [GROUP_BYTES-1:0][7:0] grp_ff, grp_in;
   logic [COUNT_W-1:0]          fill_ff, fill_in;
   logic [COUNT_W-1:0]          eff_fill;
   logic [OUT_W-1:0]            bytes_ff, bytes_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic                        last_ff, last_in;
   logic                        valid_ff, valid_in;
   logic                        out_free;
   logic                        full;

   assign out_free = !valid_ff || rsp.ready;
   assign full     = fill_ff == COUNT_W'(GROUP_BYTES);
   assign eff_fill = full ? '0 : fill_ff;
   assign cmd_ok   = cmd.finish ? (fill_ff == '0 || out_free) : (!full || out_free);

   always_comb begin
      grp_in   = grp_ff;
      fill_in  = fill_ff;
      bytes_in = bytes_ff;
      count_in = count_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp.ready;
      if (cmd.push && cmd_ok) begin
         if (full) begin
            bytes_in = OUT_W'(grp_ff);
            count_in = COUNT_W'(GROUP_BYTES);
            last_in  = 1'b0;
            valid_in = 1'b1;
         end
         // Starting a group clears the lanes above the first byte.
         for (int j = 0; j < GROUP_BYTES; j++) begin
            if (eff_fill == COUNT_W'(j)) begin
               grp_in[j] = cmd.data;
            end else if (eff_fill == '0) begin
               grp_in[j] = '0;
            end
         end
         fill_in = eff_fill + 1'b1;
      end else if (cmd.finish && cmd_ok && fill_ff != '0) begin
         bytes_in = OUT_W'(grp_ff);
         count_in = fill_ff;
         last_in  = 1'b1;
         valid_in = 1'b1;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
      grp_ff   <= grp_in;
      bytes_ff <= bytes_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.out_bytes  = bytes_ff;
   assign rsp.byte_count = count_ff;
   assign rsp.last       = last_ff;

endmodule

[bench/rans_stream_checker.sv]
// Passive checker for the geometric rANS symbol encoder: predicts the byte groups
// for every accepted input beat and compares them with the result channel.
// Depends on grans_pkg and the grans_req_if / grans_rsp_if channel interfaces.
`timescale 1ns / 100ps

module rans_stream_checker #(
   parameter int unsigned GROUP_BYTES = 8
) (
   input  logic clock,
   input  logic reset,
   grans_req_if req,
   grans_rsp_if rsp,
   output int   fail_count,
   output int   pending_count,
   output int   symbol_count,
   output int   flush_count,
   output int   beat_count,
   output int   byte_total
);
   import grans_pkg::*;

   typedef struct {
      logic [OUT_W-1:0]   out_bytes;
      logic [COUNT_W-1:0] byte_count;
      logic               last;
   } byte_group_type;

   byte_group_type     expected_groups[$];
   logic [STATE_W-1:0] coder_state;
   logic [OUT_W-1:0]   open_bits;
   int unsigned        open_fill;

   function automatic void close_group();
      byte_group_type grp;
      grp.out_bytes  = open_bits;
      grp.byte_count = COUNT_W'(open_fill);
      grp.last       = 1'b0;
      expected_groups.push_back(grp);
      open_bits = '0;
      open_fill = 0;
   endfunction

   function automatic void emit_byte(logic [7:0] data);
      open_bits = open_bits | (OUT_W'(data) << (8 * open_fill));
      open_fill++;
      if (open_fill >= GROUP_BYTES || open_fill >= 8)
         close_group();
   endfunction

   // One binary step: renormalize bytes out of the bottom, then fold the bit in.
   function automatic void code_bit(logic bit_val, logic [PROB_W-1:0] prob);
      longint unsigned freq;
      longint unsigned base;
      longint unsigned x;
      longint unsigned limit;
      base  = bit_val ? prob : 0;
      freq  = bit_val ? 65536 - prob : prob;
      if (freq == 0)
         freq = 1;
      x     = coder_state;
      limit = (64'(LOW_BOUND) >> 16) * 256 * freq;
      while (x >= limit) begin
         emit_byte(8'(x));
         x = x >> 8;
      end
      coder_state = STATE_W'(((x / freq) << 16) + (x % freq) + base);
   endfunction

   function automatic void code_item(grans_kind_type kind, logic [VALUE_W-1:0] raw,
                                     logic [PROB_W-1:0] prob);
      int unsigned first;
      int unsigned mag;
      logic        neg;
      logic [PROB_W-1:0] p;
      byte_group_type tail;
      first     = expected_groups.size();
      open_bits = '0;
      open_fill = 0;
      if (kind == KIND_FLUSH) begin
         emit_byte(coder_state[31:24]);
         emit_byte(coder_state[23:16]);
         emit_byte(coder_state[15:8]);
         emit_byte(coder_state[7:0]);
         coder_state = LOW_BOUND;
      end else begin
         p = prob;
         if (p < PROB_MIN)
            p = PROB_MIN;
         if (p > PROB_MAX)
            p = PROB_MAX;
         neg = raw[VALUE_W-1];
         mag = neg ? 256 - raw : raw;
         code_bit(1'b1, p);
         for (int unsigned k = 0; k < mag; k++)
            code_bit(1'b0, p);
         code_bit(neg, HALF_PROB);
      end
      if (open_fill > 0)
         close_group();
      if (expected_groups.size() > first) begin
         tail = expected_groups.pop_back();
         tail.last = 1'b1;
         expected_groups.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin : watch
      byte_group_type want;
      if (reset) begin
         coder_state = LOW_BOUND;
         expected_groups.delete();
      end else begin
         // A result beat at this edge can only belong to an earlier input beat,
         // so it is checked before the input beat of the same edge is predicted.
         if (rsp.valid && rsp.ready) begin
            beat_count++;
            byte_total += rsp.byte_count;
            if (expected_groups.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat bytes %h count %0d last %b",
                        $time, rsp.out_bytes, rsp.byte_count, rsp.last);
            end else begin
               want = expected_groups.pop_front();
               if (rsp.out_bytes !== want.out_bytes) begin
                  fail_count++;
                  $display("%0t: out_bytes expected %h, got %h",
                           $time, want.out_bytes, rsp.out_bytes);
               end
               if (rsp.byte_count !== want.byte_count) begin
                  fail_count++;
                  $display("%0t: byte_count expected %0d, got %0d",
                           $time, want.byte_count, rsp.byte_count);
               end
               if (rsp.last !== want.last) begin
                  fail_count++;
                  $display("%0t: last expected %b, got %b", $time, want.last, rsp.last);
               end
            end
         end
         if (req.valid && req.ready) begin
            if (req.kind == KIND_FLUSH)
               flush_count++;
            else
               symbol_count++;
            code_item(grans_kind_type'(req.kind), req.value, req.zero_prob);
         end
      end
      pending_count = expected_groups.size();
   end

endmodule

[bench/testbench.sv]
// Top of the encoder bench: clock, reset, random-gap stimulus and result stalls.
// Depends on grans_pkg, the channel interfaces, the encoder and rans_stream_checker.
`timescale 1ns / 100ps

module testbench;
   import grans_pkg::*;

   localparam int unsigned GROUP_BYTES  = 8;
   localparam int          PERIOD       = 20;
   localparam int          IDLE_LIMIT   = 10000;
   localparam int          DRAIN_CYCLES = 2400;
   localparam int          RANDOM_ITEMS = 180;
   localparam int          PHASE_ITEMS  = 45;

   logic clock = 1'b0;
   logic reset;
   logic steady = 1'b0;
   int   idle_cycles = 0;
   int   fail_count, pending_count, symbol_count, flush_count, beat_count, byte_total;

   grans_req_if req_ch ();
   grans_rsp_if rsp_ch ();

   geometric_rans_symbol_encoder #(.GROUP_BYTES(GROUP_BYTES)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   rans_stream_checker #(.GROUP_BYTES(GROUP_BYTES)) stream_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .symbol_count  (symbol_count),
      .flush_count   (flush_count),
      .beat_count    (beat_count),
      .byte_total    (byte_total)
   );

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Outside the steady phase, the result side stalls a random number of cycles before taking each beat.
   initial begin : result_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Valid stays high straight into the next beat when no gap is drawn.
   task automatic send_item(grans_kind_type kind, logic [7:0] value, logic [15:0] prob);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.value     <= value;
      req_ch.zero_prob <= prob;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // One more edge lets the checker predict the beat accepted at the last edge.
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      int             pick;
      int             mag;
      grans_kind_type kind;
      logic [7:0]     value;
      logic [15:0]    prob;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= KIND_SYMBOL;
      req_ch.value     <= '0;
      req_ch.zero_prob <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // From the reset state this symbol renormalizes nothing and yields no beat.
      send_item(KIND_SYMBOL, 8'd0,    16'd64880);
      send_item(KIND_SYMBOL, 8'd0,    16'hffff);
      send_item(KIND_SYMBOL, 8'd1,    16'd0);
      send_item(KIND_SYMBOL, 8'hff,   16'd32768);
      send_item(KIND_SYMBOL, 8'h7f,   16'd64880);
      send_item(KIND_FLUSH,  8'h5a,   16'h1234);
      // A second flush in a row drains the bare reset state.
      send_item(KIND_FLUSH,  8'ha5,   16'hedcb);
      // The largest magnitude at the smallest zero probability spills the most bytes.
      send_item(KIND_SYMBOL, 8'h80,   16'd655);
      send_item(KIND_SYMBOL, 8'h80,   16'd64880);
      send_item(KIND_SYMBOL, 8'h7f,   16'd654);
      send_item(KIND_SYMBOL, 8'd5,    16'd656);
      send_item(KIND_SYMBOL, 8'hfb,   16'd64879);
      send_item(KIND_SYMBOL, 8'd2,    16'd64881);
      send_item(KIND_SYMBOL, 8'h81,   16'd40000);
      send_item(KIND_SYMBOL, 8'd0,    16'd1);
      send_item(KIND_FLUSH,  8'd0,    16'd0);
      send_item(KIND_SYMBOL, 8'hc0,   16'hffff);
      send_item(KIND_SYMBOL, 8'd64,   16'h8000);
      send_item(KIND_FLUSH,  8'hff,   16'hffff);
      hold_until_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0 && n > 0)
            hold_until_drained();
         steady = ((n / PHASE_ITEMS) == 2);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            kind  = KIND_FLUSH;
            value = 8'($urandom);
            prob  = 16'($urandom);
         end else begin
            kind = KIND_SYMBOL;
            // Mostly small magnitudes, as a real stream has; a few go to the limit.
            if (pick < 70)
               mag = $urandom_range(0, 7);
            else if (pick < 85)
               mag = $urandom_range(8, 40);
            else
               mag = $urandom_range(0, 128);
            value = $urandom_range(0, 1) ? 8'(-mag) : 8'(mag);
            pick = $urandom_range(0, 99);
            if (pick < 40)
               prob = 16'($urandom_range(0, 65535));
            else if (pick < 70)
               prob = 16'($urandom_range(40000, 65535));
            else if (pick < 85)
               prob = 16'($urandom_range(0, 800));
            else
               prob = 16'($urandom_range(64700, 65535));
         end
         send_item(kind, value, prob);
      end
      send_item(KIND_FLUSH, 8'($urandom), 16'($urandom));

      req_ch.valid <= 1'b0;
      steady = 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_count != 0)
         $display("%0t: %0d expected result beats never arrived", $time, pending_count);
      $display("Coded %0d symbols and %0d flushes, clamped and unclamped probabilities,",
               symbol_count, flush_count);
      $display("and compared %0d result beats carrying %0d bytes.", beat_count, byte_total);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
